// ===== hdl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared codes, field widths and controller/datapath signal groups of the
// indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int KIND_W   = 3;
  localparam int VTX_W    = 8;
  localparam int KEYIN_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_EXTRACT = 3'd1,
    KIND_CHANGE  = 3'd2,
    KIND_DELETE  = 3'd3,
    KIND_REPLACE = 3'd4
  } imh_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } imh_status_t;

  // Datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CHECK,
    OP_OLD,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_RD,
    OP_DN_CMP,
    OP_FIN,
    OP_OUT
  } imh_op_t;

  // Where the decode step sends the item
  typedef enum logic [1:0] {
    DEST_FIN,
    DEST_UP,
    DEST_DOWN,
    DEST_OLD
  } imh_dest_t;

  typedef struct packed {
    imh_op_t op;
    logic    take;
    logic    load;
  } imh_cmd_t;

  typedef struct packed {
    imh_dest_t dest;
    logic      old_less;
    logic      up_root;
    logic      up_move;
    logic      up_stop_down;
    logic      dn_move;
  } imh_sts_t;

endpackage

// ===== hdl/imh_if.sv =====
// ----------------------------------------------------------------------------
// imh_req_if / imh_rsp_if
// Valid/ready channels carrying heap requests and heap results.
// ----------------------------------------------------------------------------
interface imh_req_if;
  logic                              valid;
  logic                              ready;
  logic [imh_pkg::KIND_W-1:0]        kind;
  logic [imh_pkg::VTX_W-1:0]         vertex;
  logic signed [imh_pkg::KEYIN_W-1:0] key_weight;

  modport source (output valid, kind, vertex, key_weight, input ready);
  modport sink   (input valid, kind, vertex, key_weight, output ready);
endinterface

interface imh_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [imh_pkg::VTX_W-1:0]           out_vertex;
  logic signed [imh_pkg::KEYIN_W-1:0]  out_weight;
  logic [imh_pkg::STATUS_W-1:0]        status;
  logic [imh_pkg::COUNT_W-1:0]         count;

  modport source (output valid, out_vertex, out_weight, status, count, input ready);
  modport sink   (input valid, out_vertex, out_weight, status, count, output ready);
endinterface

// ===== hdl/imh_ctrl.sv =====
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer of the heap: decode, sift-up and sift-down walks, result hold.
// ----------------------------------------------------------------------------
module imh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  imh_pkg::imh_sts_t sts,
  output imh_pkg::imh_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_OLD, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_FIN, S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Drive the datapath operation
  always_comb begin
    cmd.take = req_valid && req_ready;
    cmd.load = (state == S_OUT) && out_free;
    case (state)
      S_IDLE:   cmd.op = imh_pkg::OP_IDLE;
      S_CHECK:  cmd.op = imh_pkg::OP_CHECK;
      S_OLD:    cmd.op = imh_pkg::OP_OLD;
      S_UP_RD:  cmd.op = imh_pkg::OP_UP_RD;
      S_UP_CMP: cmd.op = imh_pkg::OP_UP_CMP;
      S_DN_RD:  cmd.op = imh_pkg::OP_DN_RD;
      S_DN_CMP: cmd.op = imh_pkg::OP_DN_CMP;
      S_FIN:    cmd.op = imh_pkg::OP_FIN;
      S_OUT:    cmd.op = imh_pkg::OP_OUT;
      default:  cmd.op = imh_pkg::OP_IDLE;
    endcase
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (sts.dest)
          imh_pkg::DEST_UP:   state_next = S_UP_RD;
          imh_pkg::DEST_DOWN: state_next = S_DN_RD;
          imh_pkg::DEST_OLD:  state_next = S_OLD;
          default:            state_next = S_FIN;
        endcase
      end
      S_OLD:    state_next = sts.old_less ? S_UP_RD : S_DN_RD;
      S_UP_RD: begin
        if (!sts.up_root)         state_next = S_UP_CMP;
        else if (sts.up_stop_down) state_next = S_DN_RD;
        else                      state_next = S_FIN;
      end
      S_UP_CMP: begin
        if (sts.up_move)          state_next = S_UP_RD;
        else if (sts.up_stop_down) state_next = S_DN_RD;
        else                      state_next = S_FIN;
      end
      S_DN_RD:  state_next = S_DN_CMP;
      S_DN_CMP: state_next = sts.dn_move ? S_DN_RD : S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/imh_datapath.sv =====
// ----------------------------------------------------------------------------
// imh_datapath
// Heap memory, vertex position memory, present flags, the moving entry and
// the result register. Sifts move a hole and write the moving entry last.
// ----------------------------------------------------------------------------
module imh_datapath #(
  parameter int CAPACITY     = 256,
  parameter int VERTEX_COUNT = 256,
  parameter int WEIGHT_BITS  = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  imh_pkg::imh_cmd_t                  cmd,
  output imh_pkg::imh_sts_t                  sts,
  input  logic [imh_pkg::KIND_W-1:0]         kind,
  input  logic [imh_pkg::VTX_W-1:0]          vertex,
  input  logic signed [imh_pkg::KEYIN_W-1:0] key_weight,
  output logic [imh_pkg::VTX_W-1:0]          out_vertex,
  output logic signed [imh_pkg::KEYIN_W-1:0] out_weight,
  output logic [imh_pkg::STATUS_W-1:0]       status,
  output logic [imh_pkg::COUNT_W-1:0]        count
);

  localparam int PW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LW     = PW + 2;
  localparam int VDEPTH = (VERTEX_COUNT < 256) ? VERTEX_COUNT : 256;
  localparam int VIW    = $clog2(VDEPTH);
  localparam int VW     = imh_pkg::VTX_W;
  localparam int WB     = WEIGHT_BITS;
  localparam int EW     = VW + WB;
  localparam logic [WB-1:0] SIGN = {1'b1, {(WB-1){1'b0}}};

  // Memories and their registered read data
  logic [EW-1:0] heap [CAPACITY];
  logic [PW-1:0] pmap [VDEPTH];
  logic [EW-1:0] a_q, b_q;
  logic [PW-1:0] map_q;
  logic [PW-1:0] a_addr, b_addr;
  logic [VIW-1:0] map_addr;
  logic          hw_en, mw_en;
  logic [PW-1:0] hw_addr, mw_data;
  logic [EW-1:0] hw_data;
  logic [VIW-1:0] mw_addr;
  logic          ren;

  // Control state
  logic [CW-1:0]  cnt, cnt_next;
  logic           vld [VDEPTH];
  logic           vld_q;
  logic           set_en, clr_en;
  logic [VIW-1:0] set_idx, clr_idx;

  // Item and moving entry
  logic [imh_pkg::KIND_W-1:0] kind_q;
  logic [VW-1:0]  vtx_q;
  logic [WB-1:0]  key_q;
  logic [PW-1:0]  p, p_next;
  logic [VW-1:0]  e_v, e_v_next;
  logic [WB-1:0]  e_k, e_k_next;
  logic           then_down, then_down_next;
  logic           moved, moved_next;
  logic [VW-1:0]  rem_v, rem_v_next;
  logic [WB-1:0]  rem_k, rem_k_next;
  logic           removed, removed_next;
  logic [imh_pkg::STATUS_W-1:0] st, st_next;

  // Derived values
  logic [WB+imh_pkg::KEYIN_W-1:0] kin_x;
  logic [WB-1:0]  key_in;
  logic [VW-1:0]  a_v, b_v;
  logic [WB-1:0]  a_k, b_k, best_k;
  logic [PW-1:0]  parent, cnt_m1;
  logic [LW-1:0]  lw, rw, cnt_w;
  logic           lv, rv, l_less, r_less;
  logic           inr, vok;
  logic [CW-1:0]  cnt_one;

  assign kin_x   = {{WB{1'b0}}, key_weight};
  assign key_in  = kin_x[WB-1:0] ^ SIGN;
  assign a_v     = a_q[EW-1:WB];
  assign a_k     = a_q[WB-1:0];
  assign b_v     = b_q[EW-1:WB];
  assign b_k     = b_q[WB-1:0];
  assign parent  = (p - PW'(1)) >> 1;
  assign cnt_one = CW'(1);
  assign cnt_m1  = PW'(cnt - cnt_one);
  assign lw      = {1'b0, p, 1'b1};
  assign rw      = lw + LW'(1);
  assign cnt_w   = LW'(cnt);
  assign lv      = lw < cnt_w;
  assign rv      = rw < cnt_w;
  assign l_less  = lv && (a_k < e_k);
  assign best_k  = l_less ? a_k : e_k;
  assign r_less  = rv && (b_k < best_k);
  assign inr     = 32'(vtx_q) < VERTEX_COUNT;
  assign vok     = inr && vld_q;
  assign ren     = (cmd.op != imh_pkg::OP_OUT);

  // Decode, sift steps and memory commands
  always_comb begin
    cnt_next       = cnt;
    p_next         = p;
    e_v_next       = e_v;
    e_k_next       = e_k;
    then_down_next = then_down;
    moved_next     = moved;
    rem_v_next     = rem_v;
    rem_k_next     = rem_k;
    removed_next   = removed;
    st_next        = st;
    set_en         = 1'b0;
    set_idx        = vtx_q[VIW-1:0];
    clr_en         = 1'b0;
    clr_idx        = a_v[VIW-1:0];
    hw_en          = 1'b0;
    hw_addr        = p;
    hw_data        = {e_v, e_k};
    mw_en          = 1'b0;
    mw_addr        = e_v[VIW-1:0];
    mw_data        = p;
    a_addr         = '0;
    b_addr         = '0;
    map_addr       = vertex[VIW-1:0];
    sts.dest         = imh_pkg::DEST_FIN;
    sts.old_less     = 1'b0;
    sts.up_root      = 1'b0;
    sts.up_move      = 1'b0;
    sts.up_stop_down = then_down && !moved;
    sts.dn_move      = 1'b0;
    case (cmd.op)
      imh_pkg::OP_IDLE: begin
        b_addr = cnt_m1;
        if (cmd.take) begin
          removed_next   = 1'b0;
          st_next        = imh_pkg::ST_OK;
          then_down_next = 1'b0;
          moved_next     = 1'b0;
        end
      end
      imh_pkg::OP_CHECK: begin
        a_addr = map_q;
        case (kind_q)
          imh_pkg::KIND_INSERT: begin
            if (!inr) st_next = imh_pkg::ST_ABSENT;
            else if (vld_q) st_next = imh_pkg::ST_PRESENT;
            else if (cnt == CW'(CAPACITY)) st_next = imh_pkg::ST_FULL;
            else begin
              set_en   = 1'b1;
              cnt_next = cnt + cnt_one;
              p_next   = PW'(cnt);
              e_v_next = vtx_q;
              e_k_next = key_q;
              sts.dest = imh_pkg::DEST_UP;
            end
          end
          imh_pkg::KIND_EXTRACT: begin
            if (cnt == '0) st_next = imh_pkg::ST_EMPTY;
            else begin
              rem_v_next   = a_v;
              rem_k_next   = a_k;
              removed_next = 1'b1;
              clr_en       = 1'b1;
              cnt_next     = cnt - cnt_one;
              if (cnt != cnt_one) begin
                e_v_next = b_v;
                e_k_next = b_k;
                p_next   = '0;
                sts.dest = imh_pkg::DEST_DOWN;
              end
            end
          end
          imh_pkg::KIND_CHANGE: begin
            if (!vok) st_next = imh_pkg::ST_ABSENT;
            else begin
              p_next   = map_q;
              e_v_next = vtx_q;
              e_k_next = key_q;
              sts.dest = imh_pkg::DEST_OLD;
            end
          end
          imh_pkg::KIND_DELETE: begin
            if (!vok) st_next = imh_pkg::ST_ABSENT;
            else begin
              clr_en   = 1'b1;
              clr_idx  = vtx_q[VIW-1:0];
              cnt_next = cnt - cnt_one;
              if (map_q != cnt_m1) begin
                e_v_next       = b_v;
                e_k_next       = b_k;
                p_next         = map_q;
                then_down_next = 1'b1;
                sts.dest       = imh_pkg::DEST_UP;
              end
            end
          end
          imh_pkg::KIND_REPLACE: begin
            if (cnt == '0) st_next = imh_pkg::ST_EMPTY;
            else if (!inr) st_next = imh_pkg::ST_ABSENT;
            else if (vld_q && (a_v != vtx_q)) st_next = imh_pkg::ST_PRESENT;
            else begin
              rem_v_next   = a_v;
              rem_k_next   = a_k;
              removed_next = 1'b1;
              clr_en       = 1'b1;
              set_en       = 1'b1;
              e_v_next     = vtx_q;
              e_k_next     = key_q;
              p_next       = '0;
              sts.dest     = imh_pkg::DEST_DOWN;
            end
          end
          default: ;
        endcase
      end
      imh_pkg::OP_OLD: begin
        sts.old_less = e_k < a_k;
      end
      imh_pkg::OP_UP_RD: begin
        a_addr      = parent;
        sts.up_root = (p == '0);
        if (sts.up_root && !sts.up_stop_down) begin
          hw_en = 1'b1;
          mw_en = 1'b1;
        end
      end
      imh_pkg::OP_UP_CMP: begin
        a_addr      = parent;
        sts.up_move = e_k < a_k;
        if (sts.up_move) begin
          hw_en      = 1'b1;
          hw_data    = a_q;
          mw_en      = 1'b1;
          mw_addr    = a_v[VIW-1:0];
          p_next     = parent;
          moved_next = 1'b1;
        end else if (!sts.up_stop_down) begin
          hw_en = 1'b1;
          mw_en = 1'b1;
        end
      end
      imh_pkg::OP_DN_RD: begin
        a_addr = lw[PW-1:0];
        b_addr = rw[PW-1:0];
      end
      imh_pkg::OP_DN_CMP: begin
        sts.dn_move = l_less || r_less;
        hw_en       = 1'b1;
        mw_en       = 1'b1;
        if (r_less) begin
          hw_data = b_q;
          mw_addr = b_v[VIW-1:0];
          p_next  = rw[PW-1:0];
        end else if (l_less) begin
          hw_data = a_q;
          mw_addr = a_v[VIW-1:0];
          p_next  = lw[PW-1:0];
        end
      end
      imh_pkg::OP_FIN: ;
      imh_pkg::OP_OUT: ;
      default: ;
    endcase
  end

  // Heap and position memories
  always_ff @(posedge clk) begin
    if (hw_en) heap[hw_addr] <= hw_data;
    if (mw_en) pmap[mw_addr] <= mw_data;
    if (ren) begin
      a_q   <= heap[a_addr];
      b_q   <= heap[b_addr];
      map_q <= pmap[map_addr];
    end
  end

  // Count and present flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      for (int i = 0; i < VDEPTH; i++) vld[i] <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (clr_en) vld[clr_idx] <= 1'b0;
      if (set_en) vld[set_idx] <= 1'b1;
    end
  end

  // Item, moving entry and result capture
  logic [WB-1:0]                  res_k;
  logic [WB+imh_pkg::KEYIN_W-1:0] res_x;
  logic [CW+imh_pkg::COUNT_W-1:0] cnt_x;
  assign res_k = removed ? (rem_k ^ SIGN) : ((cnt != '0) ? (a_k ^ SIGN) : '0);
  assign res_x = {{imh_pkg::KEYIN_W{1'b0}}, res_k};
  assign cnt_x = {{imh_pkg::COUNT_W{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= kind;
      vtx_q  <= vertex;
      key_q  <= key_in;
      vld_q  <= vld[vertex[VIW-1:0]];
    end
    p         <= p_next;
    e_v       <= e_v_next;
    e_k       <= e_k_next;
    then_down <= then_down_next;
    moved     <= moved_next;
    rem_v     <= rem_v_next;
    rem_k     <= rem_k_next;
    removed   <= removed_next;
    st        <= st_next;
    if (cmd.load) begin
      out_vertex <= removed ? rem_v : ((cnt != '0) ? a_v : '0);
      out_weight <= res_x[imh_pkg::KEYIN_W-1:0];
      status     <= st;
      count      <= cnt_x[imh_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== hdl/indexed_min_heap.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of (vertex, weight) entries with a vertex position
// map; insert, extract-min, change-key, delete and replace-min.
// ----------------------------------------------------------------------------
// A request is decoded, then sifted up or down the heap level by level, and
// its result is held; each level costs a heap memory read and a key
// compare-and-write. Items are handled one at a time; a result may wait
// while the next item is taken. Reset clears the count and every present
// flag; heap memory is not cleared.
module indexed_min_heap #(
  parameter int CAPACITY     = 256,
  parameter int VERTEX_COUNT = 256,
  parameter int WEIGHT_BITS  = 32
) (
  input logic       clk,
  input logic       rst,
  imh_req_if.sink   request,
  imh_rsp_if.source result
);

  imh_pkg::imh_cmd_t cmd;
  imh_pkg::imh_sts_t sts;

  // Sequencer
  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Heap storage and compare logic
  imh_datapath #(
    .CAPACITY     (CAPACITY),
    .VERTEX_COUNT (VERTEX_COUNT),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (request.kind),
    .vertex     (request.vertex),
    .key_weight (request.key_weight),
    .out_vertex (result.out_vertex),
    .out_weight (result.out_weight),
    .status     (result.status),
    .count      (result.count)
  );

endmodule

// ===== hdl/imh_checker.sv =====
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks of the indexed min-heap, bound to the top level.
// ----------------------------------------------------------------------------
module imh_checker #(
  parameter int CAPACITY = 256
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [imh_pkg::VTX_W-1:0]          rsp_vertex,
  input logic signed [imh_pkg::KEYIN_W-1:0] rsp_weight,
  input logic [imh_pkg::STATUS_W-1:0]       rsp_status,
  input logic [imh_pkg::COUNT_W-1:0]        rsp_count
);

  // One item at a time: no new transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an item is in work");

  // Count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp_count) <= CAPACITY))
    else $error("count beyond capacity");

  // Empty status reports an empty heap and zero fields
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == imh_pkg::ST_EMPTY)) |->
      (rsp_count == '0) && (rsp_vertex == '0) && (rsp_weight == '0))
    else $error("empty status with nonzero fields");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_vertex) &&
      $stable(rsp_weight) && $stable(rsp_status) && $stable(rsp_count))
    else $error("stalled result changed");

endmodule

bind indexed_min_heap imh_checker #(.CAPACITY(CAPACITY)) u_imh_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .rsp_valid  (result.valid),
  .rsp_ready  (result.ready),
  .rsp_vertex (result.out_vertex),
  .rsp_weight (result.out_weight),
  .rsp_status (result.status),
  .rsp_count  (result.count)
);
